// File: rtl/freq_meter_result_filter_assert.svh
// Assertion macros shared by the frequency meter result filter RTL.
`ifndef FREQ_METER_RESULT_FILTER_ASSERT_SVH
`define FREQ_METER_RESULT_FILTER_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define FMRF_ASSERT_SAME(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error("fmrf same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define FMRF_ASSERT_NEXT(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error("fmrf next-cycle check failed");

`endif

// File: rtl/fmrf_pkg.sv
// Shared constants, types and factor tables of the frequency meter result filter.
`default_nettype none
package fmrf_pkg;

    localparam int FREQ_W     = 39;
    localparam int COUNT_W    = 32;
    localparam int NUM_W      = 37;
    localparam int MULT_W     = 7;
    localparam int SCALED_W   = FREQ_W + 4;
    localparam int DIV_CNT_W  = $clog2(NUM_W);
    localparam int MODE_W     = 2;
    localparam int IDX_W      = 2;
    localparam int CFG_W      = 2;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;

    localparam logic [COUNT_W-1:0] LOW_COUNT_LIMIT = 32'd1000;

    localparam logic [MODE_W-1:0] MODE_GATE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PERIOD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    localparam logic [IDX_W-1:0] REG_METER_ENABLED = 2'd0;
    localparam logic [IDX_W-1:0] REG_GATE_TIME_SEL = 2'd1;
    localparam logic [IDX_W-1:0] REG_CLOCK_SEL     = 2'd2;
    localparam logic [IDX_W-1:0] REG_PERIODS_SEL   = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [MULT_W-1:0] gate_mult(input logic en, input logic [1:0] sel);
        logic [MULT_W-1:0] m;
        if (!en) begin
            m = 7'd100;
        end else begin
            case (sel)
                2'd0:    m = 7'd100;
                2'd1:    m = 7'd10;
                default: m = 7'd1;
            endcase
        end
        return m;
    endfunction

    function automatic logic [NUM_W-1:0] period_num(input logic en, input logic [1:0] csel,
                                                    input logic [1:0] psel);
        logic [2:0]       pidx;
        logic [2:0]       e;
        logic [NUM_W-1:0] n;
        pidx = (psel == 2'd3) ? 3'd2 : {1'b0, psel};
        e    = {1'b0, csel} + pidx;
        if (!en) begin
            n = 37'd10000000;
        end else begin
            case (e)
                3'd0:    n = 37'd1000000;
                3'd1:    n = 37'd10000000;
                3'd2:    n = 37'd100000000;
                3'd3:    n = 37'd1000000000;
                3'd4:    n = 37'd10000000000;
                default: n = 37'd100000000000;
            endcase
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// File: rtl/fmrf_serdiv.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module fmrf_serdiv (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [fmrf_pkg::NUM_W-1:0]   dividend,
    input  wire logic [fmrf_pkg::COUNT_W-1:0] divisor,
    output fmrf_pkg::div_status_t             status,
    output logic [fmrf_pkg::NUM_W-1:0]        quotient
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [fmrf_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [fmrf_pkg::COUNT_W-1:0]     rem_reg, rem_next;
    logic [fmrf_pkg::NUM_W-1:0]       quo_reg, quo_next;
    logic [fmrf_pkg::COUNT_W-1:0]     dvs_reg, dvs_next;
    logic [fmrf_pkg::COUNT_W:0]       trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[fmrf_pkg::NUM_W-1]} - {1'b0, dvs_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = fmrf_pkg::DIV_CNT_W'(fmrf_pkg::NUM_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (!trial[fmrf_pkg::COUNT_W]) begin
                rem_next = trial[fmrf_pkg::COUNT_W-1:0];
                quo_next = {quo_reg[fmrf_pkg::NUM_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[fmrf_pkg::COUNT_W-2:0], quo_reg[fmrf_pkg::NUM_W-1]};
                quo_next = {quo_reg[fmrf_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule
`default_nettype wire

// File: rtl/freq_meter_result_filter.sv
// Top level of the frequency meter result filter.
//
// Input channel s_*: one request per finished counter reading. s_tuser carries
// the mode (gate count, period count, clear), s_tdata the 32-bit count.
// Output channel m_*: exactly one result per request, in request order.
// Configuration channel cfg_*: register index and data, always ready; write
// only while no request is in flight.
// Mode clear, ignored readings and the switch to the reciprocal range go from
// accept straight to the output stage. A gate count runs the 7-step shift-add
// multiplier and then the 3-step ten-percent check. A nonzero period count runs
// the 37-step bit-serial divider and then the ten-percent check.
// One request is in work at a time; s_tready is high only when the sequencer
// is idle, so a new request is taken only once the last one is through.
// The output register parts the two sides: a new request is taken while a
// result waits, and a finished result stalls the sequencer until m_tready.
// Reset (aresetn low, synchronous) clears the state and configuration registers,
// the range flag, the previous and held frequency, and empties the output register.
`default_nettype none
`include "freq_meter_result_filter_assert.svh"
module freq_meter_result_filter (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [fmrf_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] count
    input  wire logic [fmrf_pkg::MODE_W-1:0]    s_tuser,  // [1:0] mode
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [38:0] frequency, [39] found, [40] period_range, [41] restart_period, [47:42] zero
    output logic [fmrf_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [fmrf_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [fmrf_pkg::CFG_W-1:0]     cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_DIV  = 7'b0000100,
        ST_CMPA = 7'b0001000,
        ST_CMPB = 7'b0010000,
        ST_CMPC = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t                                state_reg, state_next;
    logic                                  en_reg, en_next;
    logic [1:0]                            gsel_reg, gsel_next;
    logic [1:0]                            csel_reg, csel_next;
    logic [1:0]                            psel_reg, psel_next;
    logic                                  use_period_reg, use_period_next;
    logic [fmrf_pkg::FREQ_W-1:0]           prev_reg, prev_next;
    logic [fmrf_pkg::FREQ_W-1:0]           held_reg, held_next;
    logic                                  restart_reg, restart_next;
    logic                                  m_tvalid_reg, m_tvalid_next;
    logic [fmrf_pkg::M_TDATA_W-1:0]        m_tdata_reg, m_tdata_next;
    logic [fmrf_pkg::FREQ_W-1:0]           fr_reg, fr_next;
    logic [fmrf_pkg::FREQ_W-1:0]           addend_reg, addend_next;
    logic [fmrf_pkg::MULT_W-1:0]           mult_reg, mult_next;
    logic [fmrf_pkg::SCALED_W-1:0]         scaled_reg, scaled_next;
    logic [fmrf_pkg::SCALED_W-1:0]         p9_reg, p9_next;
    logic [fmrf_pkg::SCALED_W-1:0]         p11_reg, p11_next;
    logic                                  low_reg, low_next;

    logic                                  s_accept;
    logic [fmrf_pkg::MODE_W-1:0]           in_mode;
    logic [fmrf_pkg::COUNT_W-1:0]          in_count;
    logic                                  div_start;
    fmrf_pkg::div_status_t                 div_status;
    logic [fmrf_pkg::NUM_W-1:0]            div_quotient;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign in_mode   = s_tuser;
    assign in_count  = s_tdata[fmrf_pkg::COUNT_W-1:0];
    assign cfg_ready = 1'b1;
    assign div_start = s_accept && (in_mode == fmrf_pkg::MODE_PERIOD) && use_period_reg
                       && (in_count != '0);

    fmrf_serdiv u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (fmrf_pkg::period_num(en_reg, csel_reg, psel_reg)),
        .divisor  (in_count),
        .status   (div_status),
        .quotient (div_quotient)
    );

    always_comb begin
        en_next = en_reg;
        gsel_next = gsel_reg;
        csel_next = csel_reg;
        psel_next = psel_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                fmrf_pkg::REG_METER_ENABLED: en_next   = cfg_data[0];
                fmrf_pkg::REG_GATE_TIME_SEL: gsel_next = cfg_data;
                fmrf_pkg::REG_CLOCK_SEL:     csel_next = cfg_data;
                fmrf_pkg::REG_PERIODS_SEL:   psel_next = cfg_data;
                default:                     en_next   = en_reg;
            endcase
        end
    end

    always_comb begin
        state_next      = state_reg;
        use_period_next = use_period_reg;
        prev_next       = prev_reg;
        held_next       = held_reg;
        restart_next    = restart_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        fr_next         = fr_reg;
        addend_next     = addend_reg;
        mult_next       = mult_reg;
        scaled_next     = scaled_reg;
        p9_next         = p9_reg;
        p11_next        = p11_reg;
        low_next        = low_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    restart_next = 1'b0;
                    state_next   = ST_DONE;
                    case (in_mode)
                        fmrf_pkg::MODE_GATE: begin
                            if (!use_period_reg) begin
                                if (in_count < fmrf_pkg::LOW_COUNT_LIMIT) begin
                                    use_period_next = 1'b1;
                                end else begin
                                    fr_next     = '0;
                                    addend_next = fmrf_pkg::FREQ_W'(in_count);
                                    mult_next   = fmrf_pkg::gate_mult(en_reg, gsel_reg);
                                    state_next  = ST_MUL;
                                end
                            end
                        end
                        fmrf_pkg::MODE_PERIOD: begin
                            if (use_period_reg) begin
                                use_period_next = 1'b0;
                                restart_next    = 1'b1;
                                if (in_count == '0) begin
                                    fr_next    = '0;
                                    state_next = ST_CMPA;
                                end else begin
                                    state_next = ST_DIV;
                                end
                            end
                        end
                        fmrf_pkg::MODE_CLEAR: begin
                            held_next = '0;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                if (mult_reg[0]) begin
                    fr_next = fr_reg + addend_reg;
                end
                addend_next = {addend_reg[fmrf_pkg::FREQ_W-2:0], 1'b0};
                mult_next   = {1'b0, mult_reg[fmrf_pkg::MULT_W-1:1]};
                if (mult_reg[fmrf_pkg::MULT_W-1:1] == '0) begin
                    state_next = ST_CMPA;
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    fr_next    = fmrf_pkg::FREQ_W'(div_quotient);
                    state_next = ST_CMPA;
                end
            end
            ST_CMPA: begin
                scaled_next = {1'b0, fr_reg, 3'b000} + {3'b000, fr_reg, 1'b0};
                p9_next     = {1'b0, prev_reg, 3'b000} + {4'b0000, prev_reg};
                state_next  = ST_CMPB;
            end
            ST_CMPB: begin
                p11_next   = p9_reg + {3'b000, prev_reg, 1'b0};
                low_next   = scaled_reg < p9_reg;
                state_next = ST_CMPC;
            end
            ST_CMPC: begin
                held_next  = (low_reg || (scaled_reg > p11_reg)) ? '0 : fr_reg;
                prev_next  = fr_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b000000, restart_reg, use_period_reg,
                                     (held_reg != '0), held_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            en_reg         <= 1'b0;
            gsel_reg       <= 2'd0;
            csel_reg       <= 2'd0;
            psel_reg       <= 2'd0;
            use_period_reg <= 1'b0;
            prev_reg       <= '0;
            held_reg       <= '0;
            restart_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            en_reg         <= en_next;
            gsel_reg       <= gsel_next;
            csel_reg       <= csel_next;
            psel_reg       <= psel_next;
            use_period_reg <= use_period_next;
            prev_reg       <= prev_next;
            held_reg       <= held_next;
            restart_reg    <= restart_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        fr_reg      <= fr_next;
        addend_reg  <= addend_next;
        mult_reg    <= mult_next;
        scaled_reg  <= scaled_next;
        p9_reg      <= p9_next;
        p11_reg     <= p11_next;
        low_reg     <= low_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `FMRF_ASSERT_SAME(a_found_matches, aclk, aresetn, m_tvalid_reg, m_tdata_reg[39] == (m_tdata_reg[38:0] != '0))
    `FMRF_ASSERT_SAME(a_restart_leaves_range, aclk, aresetn, m_tvalid_reg, !(m_tdata_reg[41] && m_tdata_reg[40]))
    `FMRF_ASSERT_SAME(a_div_busy_in_div, aclk, aresetn, div_status.busy, state_reg == ST_DIV)
    `FMRF_ASSERT_NEXT(a_div_start_busy, aclk, aresetn, div_start, div_status.busy)

endmodule
`default_nettype wire
